// ===== hw/rtl/swtfs_pkg.sv =====
// Shared types, constants and codes of the sliding-window top-frequency sum core.
package swtfs_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int SUM_W           = 38;
    localparam int OUT_DW          = ((SUM_W + 7) / 8) * 8;
    localparam int CFG_W           = 7;
    localparam int CFG_IDX_W       = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_COUNT  = 1'd1;

    localparam logic [CFG_W-1:0] WINDOW_LEN_RST = 7'd8;
    localparam logic [CFG_W-1:0] TOP_COUNT_RST  = 7'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CLEAR,
        ST_RING,
        ST_SCAN_U,
        ST_DRAIN_U,
        ST_REM,
        ST_ADD,
        ST_EMIT_CHK,
        ST_PASS,
        ST_SCAN_R,
        ST_DRAIN_R,
        ST_PICK,
        ST_ACC,
        ST_FIN
    } swtfs_state_t;

    typedef struct packed {
        logic take_item;
        logic clear_state;
        logic clr_wr;
        logic ring_rd;
        logic upd_init;
        logic tbl_rd;
        logic rank_mode;
        logic tbl_rem_wr;
        logic tbl_add_wr;
        logic rank_init;
        logic pass_init;
        logic commit;
        logic acc;
        logic out_load;
    } swtfs_cmd_t;

    typedef struct packed {
        logic clear_needed;
        logic emit;
        logic picks_done;
        logic best_hit;
        logic out_free;
    } swtfs_sts_t;

endpackage

// ===== hw/rtl/swtfs_ctrl.sv =====
// Controller state machine: sequences clear, table update and ranking passes.
module swtfs_ctrl
    import swtfs_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  swtfs_sts_t                    sts,
    output swtfs_cmd_t                    cmd,
    output logic [$clog2(MAX_WINDOW)-1:0] addr
);

    localparam int AW = $clog2(MAX_WINDOW);
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_WINDOW - 1);

    swtfs_state_t    state_reg, state_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic            last;

    assign last = (idx_reg == LAST_IDX);
    assign addr = idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.take_item = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                idx_next = '0;
                if (sts.clear_needed) begin
                    cmd.clear_state = 1'b1;
                    state_next      = ST_CLEAR;
                end else begin
                    state_next = ST_RING;
                end
            end
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                idx_next   = idx_reg + 1'b1;
                if (last) begin
                    idx_next   = '0;
                    state_next = ST_RING;
                end
            end
            ST_RING: begin
                cmd.ring_rd  = 1'b1;
                cmd.upd_init = 1'b1;
                idx_next     = '0;
                state_next   = ST_SCAN_U;
            end
            ST_SCAN_U: begin
                cmd.tbl_rd = 1'b1;
                idx_next   = idx_reg + 1'b1;
                if (last) begin
                    idx_next   = '0;
                    state_next = ST_DRAIN_U;
                end
            end
            ST_DRAIN_U: state_next = ST_REM;
            ST_REM: begin
                cmd.tbl_rem_wr = 1'b1;
                state_next     = ST_ADD;
            end
            ST_ADD: begin
                cmd.tbl_add_wr = 1'b1;
                state_next     = ST_EMIT_CHK;
            end
            ST_EMIT_CHK: begin
                if (sts.emit) begin
                    cmd.rank_init = 1'b1;
                    state_next    = ST_PASS;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PASS: begin
                cmd.pass_init = 1'b1;
                idx_next      = '0;
                state_next    = sts.picks_done ? ST_FIN : ST_SCAN_R;
            end
            ST_SCAN_R: begin
                cmd.tbl_rd    = 1'b1;
                cmd.rank_mode = 1'b1;
                idx_next      = idx_reg + 1'b1;
                if (last) begin
                    idx_next   = '0;
                    state_next = ST_DRAIN_R;
                end
            end
            ST_DRAIN_R: state_next = ST_PICK;
            ST_PICK: begin
                if (sts.best_hit) begin
                    cmd.commit = 1'b1;
                    state_next = ST_ACC;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = ST_PASS;
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/swtfs_datapath.sv =====
// Datapath: ring and frequency table memories, scan compare, multiply-accumulate.
module swtfs_datapath
    import swtfs_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  swtfs_cmd_t                    cmd,
    input  logic [$clog2(MAX_WINDOW)-1:0] addr,
    output swtfs_sts_t                    sts,
    input  logic [VALUE_WIDTH-1:0]        in_value,
    input  logic                          in_restart,
    input  logic                          cfg_valid,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_wdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [SUM_W-1:0]              out_sum
);

    localparam int AW  = $clog2(MAX_WINDOW);
    localparam int CW  = $clog2(MAX_WINDOW + 1);
    localparam int PW  = (CW > CFG_W) ? CW : CFG_W;
    localparam int VW  = VALUE_WIDTH;
    localparam int PRW = VW + CW + 1;
    localparam int XW  = (PRW > SUM_W) ? PRW : SUM_W;

    // configuration and item
    logic [CFG_W-1:0] window_len_reg, top_count_reg;
    logic             clear_pend_reg;
    logic [VW-1:0]    value_reg;
    logic             restart_reg;

    // window bookkeeping
    logic [AW-1:0]    wp_reg;
    logic [CW-1:0]    fill_reg;
    logic [VW-1:0]    ring_mem [MAX_WINDOW];
    logic [VW-1:0]    ring_rd_reg;

    // frequency table
    logic [VW-1:0]    tbl_val_mem [MAX_WINDOW];
    logic [CW-1:0]    tbl_cnt_mem [MAX_WINDOW];
    logic [VW-1:0]    rd_val_reg;
    logic [CW-1:0]    rd_cnt_reg;
    logic [AW-1:0]    rd_idx_reg;
    logic             rd_vld_reg, rd_rank_reg;

    // update scan results
    logic             om_hit_reg, nm_hit_reg, ff_hit_reg;
    logic [AW-1:0]    om_idx_reg, nm_idx_reg, ff_idx_reg;
    logic [CW-1:0]    om_cnt_reg, nm_cnt_reg;

    // ranking
    logic             best_hit_reg, bound_vld_reg;
    logic [VW-1:0]    best_val_reg, bound_val_reg;
    logic [CW-1:0]    best_cnt_reg, bound_cnt_reg;
    logic [CW-1:0]    pick_cnt_reg;
    logic [PRW-1:0]   prod_reg;
    logic [SUM_W-1:0] sum_reg;
    logic             out_valid_reg;
    logic [SUM_W-1:0] out_sum_reg;

    // effective window
    logic [PW-1:0]    wl_ext, eff_ext;
    logic [CW-1:0]    win;
    logic             full;
    logic [AW:0]      old_tmp;
    logic [AW-1:0]    oldest, wp_inc;

    always_comb begin
        wl_ext = PW'(window_len_reg);
        if (window_len_reg == '0) begin
            eff_ext = PW'(1);
        end else if (wl_ext > PW'(MAX_WINDOW)) begin
            eff_ext = PW'(MAX_WINDOW);
        end else begin
            eff_ext = wl_ext;
        end
        win     = CW'(eff_ext);
        full    = (fill_reg >= win);
        old_tmp = {1'b0, wp_reg} + (AW+1)'(MAX_WINDOW) - (AW+1)'(win);
        if (old_tmp >= (AW+1)'(MAX_WINDOW)) begin
            old_tmp = old_tmp - (AW+1)'(MAX_WINDOW);
        end
        oldest = old_tmp[AW-1:0];
        wp_inc = (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : wp_reg + 1'b1;
    end

    // scan compare
    logic rd_live, eligible, better;
    always_comb begin
        rd_live  = (rd_cnt_reg != '0);
        eligible = !bound_vld_reg || (bound_cnt_reg > rd_cnt_reg) ||
                   ((bound_cnt_reg == rd_cnt_reg) &&
                    ($signed(bound_val_reg) > $signed(rd_val_reg)));
        better   = !best_hit_reg || (rd_cnt_reg > best_cnt_reg) ||
                   ((rd_cnt_reg == best_cnt_reg) &&
                    ($signed(rd_val_reg) > $signed(best_val_reg)));
    end

    // table write port
    logic          rem_go, same_val, freed;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [VW-1:0] wr_val;
    logic [CW-1:0] wr_cnt;
    always_comb begin
        rem_go   = full && om_hit_reg;
        same_val = (ring_rd_reg == value_reg);
        freed    = rem_go && (om_cnt_reg == CW'(1));
        wr_en    = 1'b0;
        wr_addr  = addr;
        wr_val   = '0;
        wr_cnt   = '0;
        if (cmd.clr_wr) begin
            wr_en = 1'b1;
        end else if (cmd.tbl_rem_wr) begin
            // oldest and newest equal: the count stays, so leave the entry alone
            wr_en   = rem_go && !same_val;
            wr_addr = om_idx_reg;
            wr_val  = ring_rd_reg;
            wr_cnt  = om_cnt_reg - 1'b1;
        end else if (cmd.tbl_add_wr) begin
            wr_val = value_reg;
            if (rem_go && same_val) begin
                wr_en = 1'b0;
            end else if (nm_hit_reg) begin
                wr_en   = 1'b1;
                wr_addr = nm_idx_reg;
                wr_cnt  = nm_cnt_reg + 1'b1;
            end else begin
                wr_en   = ff_hit_reg || freed;
                wr_addr = (ff_hit_reg && (!freed || ff_idx_reg < om_idx_reg)) ?
                          ff_idx_reg : om_idx_reg;
                wr_cnt  = CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tbl_val_mem[wr_addr] <= wr_val;
            tbl_cnt_mem[wr_addr] <= wr_cnt;
        end
        if (cmd.tbl_rd) begin
            rd_val_reg <= tbl_val_mem[addr];
            rd_cnt_reg <= tbl_cnt_mem[addr];
        end
        rd_idx_reg <= addr;
        if (cmd.tbl_add_wr) begin
            ring_mem[wp_reg] <= value_reg;
        end
        if (cmd.ring_rd) begin
            ring_rd_reg <= ring_mem[oldest];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= WINDOW_LEN_RST;
            top_count_reg  <= TOP_COUNT_RST;
            clear_pend_reg <= 1'b1;
            wp_reg         <= '0;
            fill_reg       <= '0;
            rd_vld_reg     <= 1'b0;
            rd_rank_reg    <= 1'b0;
            om_hit_reg     <= 1'b0;
            nm_hit_reg     <= 1'b0;
            ff_hit_reg     <= 1'b0;
            best_hit_reg   <= 1'b0;
            bound_vld_reg  <= 1'b0;
            pick_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            rd_vld_reg  <= cmd.tbl_rd;
            rd_rank_reg <= cmd.rank_mode;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_WINDOW_LEN: begin
                        window_len_reg <= cfg_wdata;
                        clear_pend_reg <= 1'b1;
                    end
                    REG_TOP_COUNT: top_count_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.clear_state) begin
                clear_pend_reg <= 1'b0;
                wp_reg         <= '0;
                fill_reg       <= '0;
            end
            if (cmd.tbl_add_wr) begin
                wp_reg <= wp_inc;
                if (!full) begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (cmd.upd_init) begin
                om_hit_reg <= 1'b0;
                nm_hit_reg <= 1'b0;
                ff_hit_reg <= 1'b0;
            end else if (rd_vld_reg && !rd_rank_reg) begin
                if (rd_live && rd_val_reg == ring_rd_reg) om_hit_reg <= 1'b1;
                if (rd_live && rd_val_reg == value_reg)   nm_hit_reg <= 1'b1;
                if (!rd_live)                             ff_hit_reg <= 1'b1;
            end
            if (cmd.rank_init) begin
                bound_vld_reg <= 1'b0;
                pick_cnt_reg  <= '0;
            end
            if (cmd.pass_init) begin
                best_hit_reg <= 1'b0;
            end else if (rd_vld_reg && rd_rank_reg && rd_live && eligible && better) begin
                best_hit_reg <= 1'b1;
            end
            if (cmd.commit) begin
                bound_vld_reg <= 1'b1;
                pick_cnt_reg  <= pick_cnt_reg + 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            value_reg   <= in_value;
            restart_reg <= in_restart;
        end
        if (rd_vld_reg && !rd_rank_reg) begin
            if (rd_live && rd_val_reg == ring_rd_reg && !om_hit_reg) begin
                om_idx_reg <= rd_idx_reg;
                om_cnt_reg <= rd_cnt_reg;
            end
            if (rd_live && rd_val_reg == value_reg && !nm_hit_reg) begin
                nm_idx_reg <= rd_idx_reg;
                nm_cnt_reg <= rd_cnt_reg;
            end
            if (!rd_live && !ff_hit_reg) begin
                ff_idx_reg <= rd_idx_reg;
            end
        end
        if (rd_vld_reg && rd_rank_reg && rd_live && eligible && better) begin
            best_val_reg <= rd_val_reg;
            best_cnt_reg <= rd_cnt_reg;
        end
        if (cmd.commit) begin
            bound_val_reg <= best_val_reg;
            bound_cnt_reg <= best_cnt_reg;
            // widen both operands first so the product keeps all its bits
            prod_reg      <= $signed({{(PRW-VW){best_val_reg[VW-1]}}, best_val_reg}) *
                             $signed({{(PRW-CW){1'b0}}, best_cnt_reg});
        end
        if (cmd.rank_init) begin
            sum_reg <= '0;
        end else if (cmd.acc) begin
            sum_reg <= sum_reg + SUM_W'(XW'($signed(prod_reg)));
        end
        if (cmd.out_load) begin
            out_sum_reg <= sum_reg;
        end
    end

    always_comb begin
        sts.clear_needed = clear_pend_reg || restart_reg;
        sts.emit         = full;
        sts.picks_done   = (PW'(pick_cnt_reg) >= PW'(top_count_reg));
        sts.best_hit     = best_hit_reg;
        sts.out_free     = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;

endmodule

// ===== hw/rtl/sliding_window_top_frequency_sum_core.sv =====
// Top level of the sliding-window top-frequency sum core.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-------------------------------
//  s_       | in        | s_tvalid / s_tready      | s_tdata: value; s_tuser: restart
//  m_       | out       | m_tvalid / m_tready      | m_tdata: window_sum (38b, signed)
//  cfg_     | in        | cfg_valid / cfg_ready    | cfg_index, cfg_wdata (7b)
//
// One transaction at a time. An update walks the frequency table once between one accepted
// transaction and the next. A result then adds one table walk per ranked value taken, up
// to top_count walks, and closes by loading the output register, after one more walk when
// the table runs out first. After reset, a restart or a window_len write, the next
// transaction first runs a clearing pass over all MAX_WINDOW entries of the table memory.
// Reset is synchronous, active low. A result held by m_tready low keeps the core from
// finishing the next transaction that produces a result; configuration writes are
// always taken.
module sliding_window_top_frequency_sum_core
    import swtfs_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      s_tdata,   // value, zero pad
    input  logic                                  s_tuser,   // restart
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [OUT_DW-1:0]                     m_tdata,   // window_sum, zero pad
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]                  cfg_index,
    input  logic [CFG_W-1:0]                      cfg_wdata
);

    swtfs_cmd_t                    cmd;
    swtfs_sts_t                    sts;
    logic [$clog2(MAX_WINDOW)-1:0] addr;
    logic [SUM_W-1:0]              sum;

    // registers take every write
    assign cfg_ready = 1'b1;

    swtfs_ctrl #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd),
        .addr     (addr)
    );

    swtfs_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .addr       (addr),
        .sts        (sts),
        .in_value   (s_tdata[VALUE_WIDTH-1:0]),
        .in_restart (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sum    (sum)
    );

    // pad the sum with zeros up to a whole byte
    assign m_tdata = OUT_DW'(sum);

endmodule

// ===== hw/rtl/swtfs_checker.sv =====
// Port-level checker for the sliding-window top-frequency sum core, with its bind.
module swtfs_checker
    import swtfs_pkg::*;
(
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [OUT_DW-1:0]                m_tdata,
    input logic                             cfg_ready
);

    // a taken transaction keeps the input from being ready in the following cycle
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after a transaction");

    // held result keeps its data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // pad bits above the sum stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_DW-1:SUM_W] == '0))
        else $error("nonzero pad bits on m_tdata");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_cfg_open: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind sliding_window_top_frequency_sum_core swtfs_checker u_swtfs_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);
